// ----- rtl/door_push_gesture_detector_macros.svh -----
// Assertion macros for the door push gesture detector.
// Expects clk and rst_n in the scope of each use.
`ifndef DOOR_PUSH_GESTURE_DETECTOR_MACROS_SVH
`define DOOR_PUSH_GESTURE_DETECTOR_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define DPGD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define DPGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dpgd_pkg.sv -----
// Package for the door push gesture detector: field widths, register
// indexes, reset values and the register file type. No dependencies.
`timescale 1ns / 1ps

package dpgd_pkg;

    localparam int POS_W       = 16;
    localparam int TICKS_W     = 16;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int FIRST_CHECK_TICK_DEF = 32;
    localparam int WINDOW_END_TICK_DEF  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ZONE_UPPER_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_CLOSE_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME_MINIMUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MOVE_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MOVE_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MOVE_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MOVE_MAX     = 3'd6;

    localparam logic [CFG_DATA_W-1:0] CFG_MAX_VALUE = {CFG_DATA_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] CFG_MIN_VALUE = {CFG_DATA_W{1'b0}};

    typedef struct packed {
        logic [POS_W-1:0]   zone_upper_limit;
        logic [POS_W-1:0]   soft_close_position;
        logic [TICKS_W-1:0] stop_time_minimum;
        logic [POS_W-1:0]   first_move_min;
        logic [POS_W-1:0]   first_move_max;
        logic [POS_W-1:0]   second_move_min;
        logic [POS_W-1:0]   second_move_max;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        zone_upper_limit:    CFG_MAX_VALUE,
        soft_close_position: CFG_MIN_VALUE,
        stop_time_minimum:   CFG_MIN_VALUE,
        first_move_min:      CFG_MIN_VALUE,
        first_move_max:      CFG_MAX_VALUE,
        second_move_min:     CFG_MIN_VALUE,
        second_move_max:     CFG_MAX_VALUE
    };

endpackage

// ----- rtl/dpgd_if.sv -----
// Channel interfaces for the door push gesture detector: tick input,
// result output and register write. Depends on dpgd_pkg.
`timescale 1ns / 1ps

interface dpgd_sample_if
    import dpgd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   door_position;
    logic               motor_stopped;
    logic [TICKS_W-1:0] motor_stop_ticks;

    modport source (output valid, door_position, motor_stopped, motor_stop_ticks,
                    input ready);
    modport sink   (input valid, door_position, motor_stopped, motor_stop_ticks,
                    output ready);
endinterface

interface dpgd_result_if
    import dpgd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             detected;
    logic [CNT_W-1:0] window_count;

    modport source (output valid, detected, window_count, input ready);
    modport sink   (input valid, detected, window_count, output ready);
endinterface

interface dpgd_cfg_if
    import dpgd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/door_push_gesture_detector.sv -----
// Door push gesture detector (tip-to-run), top level.
// Depends on dpgd_pkg, the channel interfaces in dpgd_if.sv and the macro header.
//
// Usage:
//   sample carries one control tick per beat: door position, motor-stopped
//   flag and motor stop ticks. result returns exactly one beat per tick:
//   the detected flag and the window counter after that tick. cfg writes
//   one of seven 16-bit registers by index; it is always ready, and writes
//   to index 7 are dropped. Write registers only while no tick is in flight.
//   A tick accepted on sample is captured in the input register, evaluated
//   against the window counter and latch, and presented on result from the
//   result register. Throughput: one tick per cycle while result is not
//   stalled; the single evaluation stage between the input register and
//   the result register sets that rate. Reset clears the valid flags of
//   both registers, the counter and latch, and loads register defaults.
//   When result stalls, the result register holds, the input register takes
//   one more tick, and sample.ready then drops until result is taken.
`timescale 1ns / 1ps
`include "door_push_gesture_detector_macros.svh"

module door_push_gesture_detector
    import dpgd_pkg::*;
#(
    parameter int FIRST_CHECK_TICK = FIRST_CHECK_TICK_DEF,
    parameter int WINDOW_END_TICK  = WINDOW_END_TICK_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    dpgd_sample_if.sink   sample,
    dpgd_result_if.source result,
    dpgd_cfg_if.sink      cfg
);

    localparam logic [CNT_W-1:0] FIRST_TICK = CNT_W'(FIRST_CHECK_TICK);
    localparam logic [CNT_W-1:0] END_TICK   = CNT_W'(WINDOW_END_TICK);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    cfg_regs_t          cfg_reg;
    cfg_regs_t          cfg_next;

    logic               in_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               stopped_reg;
    logic [TICKS_W-1:0] ticks_reg;

    logic               out_valid_reg;
    logic               detected_reg;
    logic               detected_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [POS_W-1:0]   latch_reg;
    logic [POS_W-1:0]   latch_next;

    logic               advance;
    logic               in_zone;
    logic [CNT_W-1:0]   count_inc;
    logic [POS_W-1:0]   latch_eff;
    logic               closing;
    logic [POS_W-1:0]   move;

    assign cfg.ready    = 1'b1;
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg.index)
            REG_ZONE_UPPER_LIMIT:    cfg_next.zone_upper_limit    = cfg.data;
            REG_SOFT_CLOSE_POSITION: cfg_next.soft_close_position = cfg.data;
            REG_STOP_TIME_MINIMUM:   cfg_next.stop_time_minimum   = cfg.data;
            REG_FIRST_MOVE_MIN:      cfg_next.first_move_min      = cfg.data;
            REG_FIRST_MOVE_MAX:      cfg_next.first_move_max      = cfg.data;
            REG_SECOND_MOVE_MIN:     cfg_next.second_move_min     = cfg.data;
            REG_SECOND_MOVE_MAX:     cfg_next.second_move_max     = cfg.data;
            default:                 cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        in_zone = (pos_reg < cfg_reg.zone_upper_limit) &&
                  (pos_reg > cfg_reg.soft_close_position) &&
                  stopped_reg && (ticks_reg > cfg_reg.stop_time_minimum);
        count_inc = count_reg + CNT_ONE;
        latch_eff = (count_inc == CNT_ONE) ? pos_reg : latch_reg;
        closing   = latch_eff > pos_reg;
        move      = latch_eff - pos_reg;

        detected_next = 1'b0;
        count_next    = count_reg;
        latch_next    = latch_reg;
        if (!in_zone)
        begin
            count_next = '0;
        end
        else if (count_reg < END_TICK)
        begin
            count_next = count_inc;
            latch_next = latch_eff;
            if ((count_inc == FIRST_TICK) && closing)
            begin
                if (!((move > cfg_reg.first_move_min) && (move < cfg_reg.first_move_max)))
                begin
                    count_next = '0;
                end
                latch_next = pos_reg;
            end
        end
        else
        begin
            count_next = '0;
            if (closing)
            begin
                if ((move > cfg_reg.second_move_min) && (move < cfg_reg.second_move_max))
                begin
                    detected_next = 1'b1;
                end
                else
                begin
                    latch_next = pos_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            latch_reg     <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    count_reg <= count_next;
                    latch_reg <= latch_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            pos_reg     <= sample.door_position;
            stopped_reg <= sample.motor_stopped;
            ticks_reg   <= sample.motor_stop_ticks;
        end
        if (advance && in_valid_reg)
        begin
            detected_reg <= detected_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.detected     = detected_reg;
    assign result.window_count = count_reg;

    `DPGD_ASSERT_ALWAYS(a_count_bound, count_reg <= END_TICK,
        "window counter passed the end tick")
    `DPGD_ASSERT_ALWAYS(a_detect_clears, !(out_valid_reg && detected_reg) || count_reg == '0,
        "detection reported with a nonzero window counter")
    `DPGD_ASSERT_NEXT(a_stage_moves, advance && in_valid_reg, out_valid_reg,
        "evaluated tick did not reach the result register")

endmodule
